// ----- hdl/ffba_pkg.sv -----
// Shared types and constants of the first-fit granule allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int SIZE_W  = 7;
  localparam int KEY_W   = 32;
  localparam int FIELD_W = 5;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic find_step;
    logic c_look;
    logic c_move;
    logic commit;
    logic f_read;
    logic f_cmp;
    logic f_gran;
    logic release_run;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_free;
    logic in_zero;
    logic found;
    logic last;
    logic comp_done;
    logic fhit;
  } dp_sts_t;

endpackage

// ----- hdl/first_fit_block_allocator.sv -----
// Top level of the first-fit granule allocator with compaction.
`timescale 1ns / 1ps
// A free scans the key table, reading and then comparing each table entry in turn.
// An allocate scans the free map for a run of free granules; when none is found,
// compaction walks the granules, looking up and then moving the entry at each, and
// the scan runs again. One command is in flight at a time; a finished
// result waits in the output register while the next transaction is accepted.
// Synchronous reset empties the table and marks every granule free at once.

module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int NUM_BLOCKS    = 16,
  parameter int GRANULE_BYTES = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [KEY_W-1:0]   name_key,
  input  logic [SIZE_W-1:0]  size_bytes,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic [FIELD_W-1:0] start_block,
  output logic [FIELD_W-1:0] block_count,
  output logic               did_compact
);

  // The controller sequences the scans; the datapath holds all storage.
  dp_cmd_t cmd;
  dp_sts_t sts;

  ffba_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffba_datapath #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .GRANULE_BYTES (GRANULE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .name_key    (name_key),
    .size_bytes  (size_bytes),
    .cmd         (cmd),
    .sts         (sts),
    .status      (status),
    .start_block (start_block),
    .block_count (block_count),
    .did_compact (did_compact)
  );

endmodule

// ----- hdl/ffba_datapath.sv -----
// Datapath of the allocator: tables, free map, scan counters and result registers.
`timescale 1ns / 1ps

module ffba_datapath import ffba_pkg::*; #(
  parameter int NUM_BLOCKS    = 16,
  parameter int GRANULE_BYTES = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                command,
  input  logic [KEY_W-1:0]    name_key,
  input  logic [SIZE_W-1:0]   size_bytes,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  output logic [STAT_W-1:0]   status,
  output logic [FIELD_W-1:0]  start_block,
  output logic [FIELD_W-1:0]  block_count,
  output logic                did_compact
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int GW = $clog2(NUM_BLOCKS + 1);
  localparam int TAB_N = 2 ** SIZE_W;

  // Granules needed for each byte size, fixed at elaboration.
  logic [SIZE_W-1:0] need_tab [TAB_N];
  for (genvar i = 0; i < TAB_N; i++) begin : g_need
    assign need_tab[i] = SIZE_W'((i + GRANULE_BYTES - 1) / GRANULE_BYTES);
  end

  // Table storage: valid bits and starts in flops, keys and sizes in memories.
  logic [NUM_BLOCKS-1:0] entry_valid;
  logic [GW-1:0]         entry_start [NUM_BLOCKS];
  logic [KEY_W-1:0]      key_mem [NUM_BLOCKS];
  logic [GW-1:0]         gran_mem [NUM_BLOCKS];
  logic [KEY_W-1:0]      key_rd;
  logic [GW-1:0]         gran_rd;
  logic [NUM_BLOCKS-1:0] free_map;

  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] need_r;
  logic [IW-1:0]     g;
  logic [GW-1:0]     run;
  logic [GW-1:0]     pos;
  logic [GW-1:0]     s_r;
  logic              comp_r;
  logic [IW-1:0]     cm_e;
  logic              cm_hit;
  logic [IW-1:0]     best;
  logic [GW-1:0]     best_start;
  logic              fhit;

  logic [STAT_W-1:0]  res_status;
  logic [FIELD_W-1:0] res_start;
  logic [FIELD_W-1:0] res_count;
  logic               res_comp;

  function automatic logic [NUM_BLOCKS-1:0] run_mask(input logic [GW-1:0] st,
                                                     input logic [GW-1:0] cnt);
    logic [NUM_BLOCKS-1:0] m;
    logic [GW:0]           ip;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      ip   = (GW + 1)'(i + 1);
      m[i] = (ip >= {1'b0, st}) && (ip < ({1'b0, st} + {1'b0, cnt}));
    end
    return m;
  endfunction

  logic              last;
  logic [GW-1:0]     run_new;
  logic              hit;
  logic [GW-1:0]     start1;
  logic [IW-1:0]     slot;
  logic              slot_ok;
  logic [IW-1:0]     match_e;
  logic              match_any;
  logic [GW-1:0]     pos_new;
  logic [NUM_BLOCKS-1:0] amask;
  logic [NUM_BLOCKS-1:0] fmask;
  logic [NUM_BLOCKS-1:0] top_free;
  logic [IW-1:0]     gran_addr;

  assign last    = (g == IW'(NUM_BLOCKS - 1));
  assign run_new = free_map[g] ? GW'(run + GW'(1)) : '0;
  assign hit     = (SIZE_W'(run_new) == need_r);
  assign start1  = GW'(GW'(g) + GW'(1) - run_new + GW'(1));
  assign pos_new = GW'(pos + gran_rd);
  assign amask   = run_mask(s_r, GW'(need_r));
  assign fmask   = run_mask(best_start, gran_rd);

  always_comb begin
    slot      = '0;
    slot_ok   = 1'b0;
    match_e   = '0;
    match_any = 1'b0;
    for (int e = NUM_BLOCKS - 1; e >= 0; e--) begin
      if (!entry_valid[e]) begin
        slot    = IW'(e);
        slot_ok = 1'b1;
      end
      if (entry_valid[e] && entry_start[e] == GW'(GW'(g) + GW'(1))) begin
        match_e   = IW'(e);
        match_any = 1'b1;
      end
    end
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      top_free[i] = (GW'(i) >= pos_new);
    end
  end

  assign gran_addr = cmd.c_look ? match_e : best;

  always_ff @(posedge clk) begin
    if (cmd.f_read) begin
      key_rd <= key_mem[g];
    end
    gran_rd <= gran_mem[gran_addr];
    if (cmd.commit && slot_ok) begin
      key_mem[slot]  <= key_r;
      gran_mem[slot] <= GW'(need_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      free_map    <= '1;
      comp_r      <= 1'b0;
      fhit        <= 1'b0;
      cm_hit      <= 1'b0;
    end else begin
      if (cmd.latch) begin
        key_r      <= name_key;
        need_r     <= need_tab[size_bytes];
        g          <= '0;
        run        <= '0;
        pos        <= '0;
        comp_r     <= 1'b0;
        fhit       <= 1'b0;
        res_status <= ST_FULL;
        res_start  <= '0;
        res_count  <= '0;
        res_comp   <= 1'b0;
      end
      if (cmd.find_step) begin
        g   <= last ? '0 : IW'(g + IW'(1));
        run <= run_new;
        if (hit) begin
          s_r <= start1;
        end
      end
      if (cmd.c_look) begin
        cm_e   <= match_e;
        cm_hit <= match_any;
      end
      if (cmd.c_move) begin
        if (cm_hit) begin
          entry_start[cm_e] <= GW'(pos + GW'(1));
          pos               <= pos_new;
        end
        g <= last ? '0 : IW'(g + IW'(1));
        if (last) begin
          free_map <= cm_hit ? top_free : run_mask(GW'(pos + GW'(1)), GW'(NUM_BLOCKS));
          comp_r   <= 1'b1;
          res_comp <= 1'b1;
          run      <= '0;
        end
      end
      if (cmd.commit && slot_ok) begin
        entry_valid[slot] <= 1'b1;
        entry_start[slot] <= s_r;
        free_map          <= free_map & ~amask;
        res_status        <= ST_OK;
        res_start         <= FIELD_W'(s_r);
        res_count         <= FIELD_W'(need_r);
      end
      if (cmd.f_cmp) begin
        if (entry_valid[g] && key_rd == key_r && (!fhit || entry_start[g] < best_start)) begin
          best       <= g;
          best_start <= entry_start[g];
          fhit       <= 1'b1;
        end
        g <= last ? '0 : IW'(g + IW'(1));
      end
      if (cmd.f_gran && !fhit) begin
        res_status <= ST_NOTFOUND;
      end
      if (cmd.release_run) begin
        entry_valid[best] <= 1'b0;
        free_map          <= free_map | fmask;
        res_status        <= ST_OK;
        res_start         <= FIELD_W'(best_start);
        res_count         <= FIELD_W'(gran_rd);
      end
      if (cmd.load_out) begin
        status      <= res_status;
        start_block <= res_start;
        block_count <= res_count;
        did_compact <= res_comp;
      end
    end
  end

  assign sts.in_free   = (command == CMD_FREE);
  assign sts.in_zero   = (size_bytes == '0);
  assign sts.found     = hit;
  assign sts.last      = last;
  assign sts.comp_done = comp_r;
  assign sts.fhit      = fhit;

  // A new allocation only ever covers granules that were free.
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && slot_ok) |-> ((free_map & amask) == amask))
    else $error("allocation overlaps live granules");

  // A released run was fully allocated before the release.
  a_release_used: assert property (@(posedge clk) disable iff (rst)
    cmd.release_run |-> ((free_map & fmask) == '0))
    else $error("released run was already free");

  // Compaction runs at most once for one command.
  a_single_compact: assert property (@(posedge clk) disable iff (rst)
    cmd.c_look |-> !comp_r)
    else $error("second compaction in one command");

endmodule

// ----- hdl/ffba_controller.sv -----
// Controller state machine of the allocator.
`timescale 1ns / 1ps

module ffba_controller import ffba_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_FIND   = 10'b0000000010,
    S_CLOOK  = 10'b0000000100,
    S_CMOVE  = 10'b0000001000,
    S_COMMIT = 10'b0000010000,
    S_FREAD  = 10'b0000100000,
    S_FCMP   = 10'b0001000000,
    S_FGRAN  = 10'b0010000000,
    S_FREL   = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (sts.in_free) begin
            state_next = S_FREAD;
          end else if (sts.in_zero) begin
            state_next = S_RESP;
          end else begin
            state_next = S_FIND;
          end
        end
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.found) begin
          state_next = S_COMMIT;
        end else if (sts.last) begin
          state_next = sts.comp_done ? S_RESP : S_CLOOK;
        end
      end
      S_CLOOK: begin
        cmd.c_look = 1'b1;
        state_next = S_CMOVE;
      end
      S_CMOVE: begin
        cmd.c_move = 1'b1;
        state_next = sts.last ? S_FIND : S_CLOOK;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_RESP;
      end
      S_FREAD: begin
        cmd.f_read = 1'b1;
        state_next = S_FCMP;
      end
      S_FCMP: begin
        cmd.f_cmp  = 1'b1;
        state_next = sts.last ? S_FGRAN : S_FREAD;
      end
      S_FGRAN: begin
        cmd.f_gran = 1'b1;
        state_next = sts.fhit ? S_FREL : S_RESP;
      end
      S_FREL: begin
        cmd.release_run = 1'b1;
        state_next      = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
